// ===== hdl/tmtw_pkg.sv =====
`default_nettype none

package tmtw_pkg;

  // One screen cell: attribute in the high byte, character in the low byte.
  typedef logic [15:0] cell_t;
  typedef logic [7:0]  byte_t;

  localparam int unsigned POS_W = 11;   // width of the cursor and cell index fields

  localparam byte_t NEWLINE_CODE = 8'h0A;
  localparam byte_t BLANK_CODE   = 8'h20;
  localparam byte_t RESET_COLOR  = 8'h0F;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/tmtw_ram.sv =====
`default_nettype none

module tmtw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/text_mode_terminal_writer.sv =====
`default_nettype none

// Channel       Ports                                             Handshake
// ------------  ------------------------------------------------  ---------------------------
// item in       operation, char_code, cell_index                  taken when start && !busy
// result out    cell_value, cursor_position, scrolled             one-cycle strobe on done
// color reg     text_color                                        written when text_color_we
//
// After reset the block sweeps the cell store, one cell per cycle, writing blank
// white-on-black; busy stays high until the sweep has covered all ROWS*COLUMNS cells.
// A read or a plain put goes from start through the store access and then the
// registered result, which is presented with done.
// A put that scrolls walks the store through its single write port: a read state
// and a write state per moved cell, then a fill state per blank cell.
// The result cannot be held off; done is high for exactly one cycle per item.

module text_mode_terminal_writer
  import tmtw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             operation,
  input  wire logic [7:0]       char_code,
  input  wire logic [POS_W-1:0] cell_index,
  input  wire logic             text_color_we,
  input  wire logic [7:0]       text_color,
  output logic                  done,
  output logic      [15:0]      cell_value,
  output logic      [POS_W-1:0] cursor_position,
  output logic                  scrolled
);

  localparam int unsigned CELLS     = ROWS * COLUMNS;
  localparam int unsigned AW        = $clog2(CELLS);
  localparam int unsigned CLW       = $clog2(COLUMNS);
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CW        = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int unsigned COPY_LAST = (ROWS - 1) * COLUMNS - 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SC_RD = 3'd3;
  localparam logic [2:0] ST_SC_WR = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;

  logic [2:0]       state;
  logic [7:0]       color;
  logic [RW-1:0]    row;
  logic [CLW-1:0]   col;
  logic [AW-1:0]    row_base;   // always row * COLUMNS, kept by adding COLUMNS
  logic [AW-1:0]    ptr;        // sweep pointer for clear and scroll
  logic             item_op;
  logic [7:0]       item_char;
  logic [POS_W-1:0] item_idx;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  cell_t            ram_wdata;
  logic [AW-1:0]    ram_raddr;
  cell_t            ram_rdata;

  logic [CW-1:0]    idx_ext;
  logic [CW-1:0]    pos_ext;
  logic [AW-1:0]    cursor_addr;
  logic             accept;
  logic             col_last;
  logic             row_last;
  logic             adv_row;
  logic             idx_in_range;

  assign accept      = start && !busy;
  assign busy        = (state != ST_IDLE);
  assign cursor_addr = AW'(row_base + AW'(col));
  assign pos_ext     = CW'(cursor_addr);
  assign cursor_position = pos_ext[POS_W-1:0];
  assign col_last    = (col == CLW'(COLUMNS - 1));
  assign row_last    = (row == RW'(ROWS - 1));

  // A put leaves the row on newline or when the cursor passes the last column.
  assign adv_row = (item_char == NEWLINE_CODE) || col_last;

  // Compare the read index at full width so that indexes past the grid read zero.
  assign idx_ext      = CW'(item_idx);
  assign idx_in_range = (idx_ext < CW'(CELLS));

  // Read port: the item's index while waiting for work, the source row while scrolling.
  always_comb begin
    logic [CW-1:0] in_ext;
    in_ext = CW'(cell_index);
    if (state == ST_SC_RD) begin
      ram_raddr = AW'(ptr + AW'(COLUMNS));
    end else begin
      ram_raddr = in_ext[AW-1:0];
    end
  end

  // Write port: sweep during clear, scroll and fill; cursor cell on a plain put.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = {color, BLANK_CODE};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {RESET_COLOR, BLANK_CODE};
      end
      ST_EXEC: begin
        ram_we    = (item_op == OP_PUT) && (item_char != NEWLINE_CODE);
        ram_waddr = cursor_addr;
        ram_wdata = {color, item_char};
      end
      ST_SC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  tmtw_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Color register takes writes in any state.
  always_ff @(posedge clk) begin
    if (rst) begin
      color <= RESET_COLOR;
    end else if (text_color_we) begin
      color <= text_color;
    end
  end

  // Hold the accepted transaction for the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= operation;
      item_char <= char_code;
      item_idx  <= cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ptr      <= '0;
      row      <= '0;
      col      <= '0;
      row_base <= '0;
      done     <= 1'b0;
      scrolled <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          ptr <= AW'(ptr + 1'b1);
          if (ptr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          scrolled <= 1'b0;
          if (item_op == OP_READ) begin
            // Read: return the cell, leave the cursor alone.
            cell_value <= idx_in_range ? ram_rdata : '0;
            done       <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            cell_value <= '0;
            if (adv_row) begin
              col <= '0;
            end else begin
              col <= CLW'(col + 1'b1);
            end
            if (adv_row && row_last) begin
              // Past the bottom: keep the cursor on the last row, shift the grid up.
              scrolled <= 1'b1;
              ptr      <= '0;
              state    <= ST_SC_RD;
            end else begin
              if (adv_row) begin
                row      <= RW'(row + 1'b1);
                row_base <= AW'(row_base + AW'(COLUMNS));
              end
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_SC_RD: begin
          state <= ST_SC_WR;
        end
        ST_SC_WR: begin
          ptr <= AW'(ptr + 1'b1);
          if (ptr == AW'(COPY_LAST)) begin
            state <= ST_FILL;
          end else begin
            state <= ST_SC_RD;
          end
        end
        ST_FILL: begin
          ptr <= AW'(ptr + 1'b1);
          if (ptr == AW'(CELLS - 1)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------

  // A result only appears once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe while busy");

  // An accepted transaction always goes to the execute cycle next.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted transaction did not execute");

  // A scrolling result leaves the cursor on the last row at column 0.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (row_last && (col == '0)))
    else $error("scroll left the cursor off the last row");

  // The column never runs past the end of a line.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (CW'(col) < CW'(COLUMNS)))
    else $error("cursor column out of range");

endmodule

`default_nettype wire
